// ===== rtl/eiwc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the edge implication window checker
// no dependencies

package eiwc_pkg;

    // width of the sampled input and output vectors
    localparam int VEC_WIDTH = 32;
    // config field widths
    localparam int BIT_IDX_W = 5;
    localparam int DELAY_W   = 6;
    // apb port geometry: eight 32-bit registers at byte address 4*i
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_REQ_FROM_OUTPUT = 3'd0,
        REG_REQ_ON_FALL     = 3'd1,
        REG_REQ_BIT         = 3'd2,
        REG_WINDOW_START    = 3'd3,
        REG_WINDOW_END      = 3'd4,
        REG_ACK_FROM_OUTPUT = 3'd5,
        REG_ACK_ON_FALL     = 3'd6,
        REG_ACK_BIT         = 3'd7
    } t_reg_idx;

    localparam logic [DELAY_W-1:0] WINDOW_RESET = 6'd1;

    typedef struct packed {
        logic [VEC_WIDTH-1:0] in_bits;
        logic [VEC_WIDTH-1:0] out_bits;
        logic                 last_cycle;
    } t_in_beat;

    typedef struct packed {
        logic trigger_seen;
        logic ack_seen;
        logic fail_now;
        logic passing;
    } t_out_beat;

    typedef struct packed {
        logic                 req_from_output;
        logic                 req_on_fall;
        logic [BIT_IDX_W-1:0] req_bit;
        logic [DELAY_W-1:0]   window_start;
        logic [DELAY_W-1:0]   window_end;
        logic                 ack_from_output;
        logic                 ack_on_fall;
        logic [BIT_IDX_W-1:0] ack_bit;
    } t_cfg;

    // selected bit of a vector, zero past the vector width
    function automatic logic pick_bit(logic [VEC_WIDTH-1:0] vec, logic [BIT_IDX_W-1:0] idx);
        logic r;
        r = 1'b0;
        if (int'(idx) < VEC_WIDTH) begin
            r = vec[idx];
        end
        return r;
    endfunction

endpackage

// ===== rtl/eiwc_regs.sv =====
`timescale 1ns / 1ps
// apb configuration register file of the checker
// uses eiwc_pkg

module eiwc_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eiwc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [eiwc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [eiwc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output eiwc_pkg::t_cfg                  o_cfg
);
    import eiwc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg              <= '0;
            r_cfg.window_start <= WINDOW_RESET;
            r_cfg.window_end   <= WINDOW_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_REQ_FROM_OUTPUT: r_cfg.req_from_output <= pwdata[0];
                REG_REQ_ON_FALL:     r_cfg.req_on_fall     <= pwdata[0];
                REG_REQ_BIT:         r_cfg.req_bit         <= pwdata[BIT_IDX_W-1:0];
                REG_WINDOW_START:    r_cfg.window_start    <= pwdata[DELAY_W-1:0];
                REG_WINDOW_END:      r_cfg.window_end      <= pwdata[DELAY_W-1:0];
                REG_ACK_FROM_OUTPUT: r_cfg.ack_from_output <= pwdata[0];
                REG_ACK_ON_FALL:     r_cfg.ack_on_fall     <= pwdata[0];
                REG_ACK_BIT:         r_cfg.ack_bit         <= pwdata[BIT_IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_REQ_FROM_OUTPUT: prdata[0] = r_cfg.req_from_output;
            REG_REQ_ON_FALL:     prdata[0] = r_cfg.req_on_fall;
            REG_REQ_BIT:         prdata[BIT_IDX_W-1:0] = r_cfg.req_bit;
            REG_WINDOW_START:    prdata[DELAY_W-1:0] = r_cfg.window_start;
            REG_WINDOW_END:      prdata[DELAY_W-1:0] = r_cfg.window_end;
            REG_ACK_FROM_OUTPUT: prdata[0] = r_cfg.ack_from_output;
            REG_ACK_ON_FALL:     prdata[0] = r_cfg.ack_on_fall;
            REG_ACK_BIT:         prdata[BIT_IDX_W-1:0] = r_cfg.ack_bit;
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== rtl/eiwc_track.sv =====
`timescale 1ns / 1ps
// edge detect, pending trigger vector and sticky pass flag
// uses eiwc_pkg

module eiwc_track #(
    parameter int MAX_DELAY = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  eiwc_pkg::t_in_beat i_beat,
    input  eiwc_pkg::t_cfg    i_cfg,
    output eiwc_pkg::t_out_beat o_res
);
    import eiwc_pkg::*;

    localparam logic [DELAY_W-1:0] MAX_D = DELAY_W'(MAX_DELAY);

    logic [VEC_WIDTH-1:0] r_prev_in, n_prev_in;
    logic [VEC_WIDTH-1:0] r_prev_out, n_prev_out;
    logic                 r_have_prev, n_have_prev;
    logic [MAX_DELAY-1:0] r_pending, n_pending;
    logic                 r_pass, n_pass;

    logic [DELAY_W-1:0] w_ws, w_we, w_we_cl;
    logic               w_req_now, w_req_before, w_ack_now, w_ack_before;
    logic               w_trig, w_ack;
    logic [MAX_DELAY:0] w_aged, w_win, w_tail, w_kept, w_failed;

    // clamp the window to the delay range, end never below start
    assign w_ws    = (i_cfg.window_start > MAX_D) ? MAX_D : i_cfg.window_start;
    assign w_we_cl = (i_cfg.window_end > MAX_D) ? MAX_D : i_cfg.window_end;
    assign w_we    = (w_we_cl < w_ws) ? w_ws : w_we_cl;

    assign w_req_now    = i_cfg.req_from_output ? pick_bit(i_beat.out_bits, i_cfg.req_bit)
                                                : pick_bit(i_beat.in_bits, i_cfg.req_bit);
    assign w_req_before = i_cfg.req_from_output ? pick_bit(r_prev_out, i_cfg.req_bit)
                                                : pick_bit(r_prev_in, i_cfg.req_bit);
    assign w_ack_now    = i_cfg.ack_from_output ? pick_bit(i_beat.out_bits, i_cfg.ack_bit)
                                                : pick_bit(i_beat.in_bits, i_cfg.ack_bit);
    assign w_ack_before = i_cfg.ack_from_output ? pick_bit(r_prev_out, i_cfg.ack_bit)
                                                : pick_bit(r_prev_in, i_cfg.ack_bit);

    assign w_trig = r_have_prev && (i_cfg.req_on_fall ? (!w_req_now && w_req_before)
                                                      : (w_req_now && !w_req_before));
    assign w_ack  = r_have_prev && (i_cfg.ack_on_fall ? (!w_ack_now && w_ack_before)
                                                      : (w_ack_now && !w_ack_before));

    // age by one, new trigger at age zero
    assign w_aged = {r_pending, w_trig};

    always_comb begin
        for (int a = 0; a <= MAX_DELAY; a++) begin
            w_win[a]  = (DELAY_W'(a) >= w_ws) && (DELAY_W'(a) <= w_we);
            w_tail[a] = (DELAY_W'(a) >= w_we);
        end
    end

    assign w_kept   = w_ack ? (w_aged & ~w_win) : w_aged;
    assign w_failed = i_beat.last_cycle ? w_kept : (w_kept & w_tail);

    always_comb begin
        n_pass = r_pass && (w_failed == '0);
        if (i_beat.last_cycle) begin
            n_pending   = '0;
            n_have_prev = 1'b0;
            n_prev_in   = '0;
            n_prev_out  = '0;
        end else begin
            // top age is always at or past the window end, so it never stays
            n_pending   = w_kept[MAX_DELAY-1:0] & ~w_failed[MAX_DELAY-1:0];
            n_have_prev = 1'b1;
            n_prev_in   = i_beat.in_bits;
            n_prev_out  = i_beat.out_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_in   <= '0;
            r_prev_out  <= '0;
            r_have_prev <= 1'b0;
            r_pending   <= '0;
            r_pass      <= 1'b1;
        end else if (i_fire) begin
            r_prev_in   <= n_prev_in;
            r_prev_out  <= n_prev_out;
            r_have_prev <= n_have_prev;
            r_pending   <= n_pending;
            r_pass      <= n_pass;
        end
    end

    assign o_res.trigger_seen = w_trig;
    assign o_res.ack_seen     = w_ack;
    assign o_res.fail_now     = (w_failed != '0);
    assign o_res.passing      = n_pass;

endmodule

// ===== rtl/edge_implication_window_checker_core.sv =====
`timescale 1ns / 1ps
// edge implication window checker, top level
// uses eiwc_pkg, eiwc_regs, eiwc_track
//
// monitors the rule "edge on the trigger bit, then an edge on the ack bit
// within window_start..window_end cycles". each input beat is one sampled
// design cycle (input vector, output vector, last flag); each beat gives
// exactly one result beat (trigger_seen, ack_seen, fail_now, passing).
// both channels use valid/stall; a beat moves when valid is high and stall low.
// an accepted beat waits in the input register; its result is computed from it
// combinationally and loaded into the result register once that slot is free.
// throughput is one beat per clock while the receiver does not stall, set by
// the single pass through the edge detect and pending-age update between the
// input register and the result register. when the receiver stalls, the result
// register holds and the input register still takes one more beat; stall goes
// back upstream only once both are full. reset (synchronous, active low) empties
// both registers, clears all pending triggers, sets passing and loads the config
// defaults. config is to be written over apb while no beat is in flight; the
// block itself does not enforce this. pready is always high.

module edge_implication_window_checker_core #(
    parameter int MAX_DELAY = 63
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sampled cycle beats in
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  eiwc_pkg::t_in_beat              i_in_beat,
    // result beats out
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output eiwc_pkg::t_out_beat             o_out_beat,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eiwc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [eiwc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [eiwc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import eiwc_pkg::*;

    t_cfg      w_cfg;
    t_out_beat w_res;

    // input register
    logic      r_in_valid;
    t_in_beat  r_in_beat;
    // result register
    logic      r_out_valid;
    t_out_beat r_out_beat;

    logic w_out_free;  // result slot can take a new beat this cycle
    logic w_fire;      // input register beat is processed this cycle
    logic w_in_take;   // a new input beat is accepted this cycle

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    eiwc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    eiwc_track #(
        .MAX_DELAY (MAX_DELAY)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_beat  (r_in_beat),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // input register: refills whenever it empties or is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || w_fire) begin
            r_in_valid <= w_in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_beat <= i_in_beat;
        end
    end

    // result register: holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_beat <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ===== rtl/eiwc_checker.sv =====
`timescale 1ns / 1ps
// port level checks of the edge implication window checker, with bind
// uses eiwc_pkg, attaches to edge_implication_window_checker_core

module eiwc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input eiwc_pkg::t_out_beat o_out_beat
);
    import eiwc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    // a failure always clears passing in the same beat
    a_fail_clears_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.fail_now |-> !o_out_beat.passing)
        else $error("fail_now without passing low");

    // passing is sticky once low
    a_pass_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.passing |=> !o_out_valid || !o_out_beat.passing)
        else $error("passing came back high");

    // upstream only sees stall when a full result is stalled downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free result slot");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind edge_implication_window_checker_core eiwc_checker u_eiwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);
